// ===== src/cau_pkg.sv =====
// ============================================================================
// cau_pkg - shared types for the complex arithmetic unit
// Operation codes, internal operation classes, status codes, pipeline control.
// ============================================================================
`default_nettype none

package cau_pkg;

    // external operation codes
    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB_AB = 4'd1,
        OP_SUB_BA = 4'd2,
        OP_MUL    = 4'd3,
        OP_DIV_AB = 4'd4,
        OP_DIV_BA = 4'd5,
        OP_MAG_A  = 4'd6,
        OP_MAG_B  = 4'd7
    } op_t;

    // internal classes after operand steering
    typedef enum logic [2:0] {
        CLS_ADD,
        CLS_SUB,
        CLS_MUL,
        CLS_DIV,
        CLS_MAG,
        CLS_BAD
    } cls_t;

    localparam int CLS_W = $bits(cls_t);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIVZ = 2'd1,
        ST_BAD  = 2'd2,
        ST_SAT  = 2'd3
    } status_t;

    // control word that rides along the back-end pipeline
    typedef struct packed {
        logic vld;
        cls_t cls;
        logic neg0;
        logic neg1;
        logic divz;
    } ctl_t;

endpackage

`default_nettype wire

// ===== src/complex_arithmetic_unit.sv =====
// ============================================================================
// complex_arithmetic_unit - complex add/sub/mul/div/magnitude in fixed point
// Two signed complex operands in, one saturated complex result and status out.
// ============================================================================
// Usage:
//   Request channel: drive operation and the four operand parts with start
//   high; the request is taken at a rising edge where busy is low.
//   Result channel: done is high for exactly one cycle with res_real,
//   res_imag and status valid; there is no backpressure, so the consumer
//   must capture the result in that cycle.
// Path: queue, products, sums, lane setup, DATA_WIDTH + 1 iteration
//   stages, output register. Every opcode takes the same path, so results
//   leave in request order.
// Throughput: one request per cycle while busy is low. The divider and
//   square root are unrolled one bit per pipeline stage (DATA_WIDTH + 1
//   stages), so nothing iterates in place.
// Structure: front end steers operands per opcode and pushes into a
//   two-entry queue; the back end drains it every cycle into the pipeline.
//   busy only reflects a full queue.
// Reset: rst_n clears all valid bits and the queue; in-flight requests are
//   dropped. Data registers are not reset.
// ============================================================================
`default_nettype none

module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [3:0]                   operation,
    input  logic signed [DATA_WIDTH-1:0] a_real,
    input  logic signed [DATA_WIDTH-1:0] a_imag,
    input  logic signed [DATA_WIDTH-1:0] b_real,
    input  logic signed [DATA_WIDTH-1:0] b_imag,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] res_real,
    output logic signed [DATA_WIDTH-1:0] res_imag,
    output logic [1:0]                   status
);

    // queue -> back end
    logic                         item_vld;
    cls_t                         item_cls;
    logic signed [DATA_WIDTH-1:0] x_r, x_i, y_r, y_i;

    // intake: opcode decode, operand swap for b/a and |b|, queue
    cau_front #(
        .W (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .a_real    (a_real),
        .a_imag    (a_imag),
        .b_real    (b_real),
        .b_imag    (b_imag),
        .item_vld  (item_vld),
        .item_cls  (item_cls),
        .x_r       (x_r),
        .x_i       (x_i),
        .y_r       (y_r),
        .y_i       (y_i)
    );

    // arithmetic: products, sums, divide/root pipeline, saturation
    cau_back #(
        .W (DATA_WIDTH),
        .F (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (item_vld),
        .in_cls   (item_cls),
        .x_r      (x_r),
        .x_i      (x_i),
        .y_r      (y_r),
        .y_i      (y_i),
        .done     (done),
        .res_real (res_real),
        .res_imag (res_imag),
        .status   (status)
    );

endmodule

`default_nettype wire

// ===== src/cau_fifo.sv =====
// ============================================================================
// cau_fifo - small request queue
// Register-based FIFO between the front end and the arithmetic back end.
// ============================================================================
`default_nettype none

module cau_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNTW'(DEPTH));
    assign do_wr   = push && !full;
    assign do_rd   = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(DEPTH))
        else $error("fifo count beyond depth");

    a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("fifo count missed a write");

    a_cnt_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (do_rd && !do_wr) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("fifo count missed a read");

endmodule

`default_nettype wire

// ===== src/cau_front.sv =====
// ============================================================================
// cau_front - request intake
// Accepts requests, steers operands per opcode, queues them for the back end.
// ============================================================================
`default_nettype none

module cau_front
    import cau_pkg::*;
#(
    parameter int W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [3:0]          operation,
    input  logic signed [W-1:0] a_real,
    input  logic signed [W-1:0] a_imag,
    input  logic signed [W-1:0] b_real,
    input  logic signed [W-1:0] b_imag,
    output logic                item_vld,
    output cls_t                item_cls,
    output logic signed [W-1:0] x_r,
    output logic signed [W-1:0] x_i,
    output logic signed [W-1:0] y_r,
    output logic signed [W-1:0] y_i
);

    localparam int IW = CLS_W + 4 * W;

    cls_t                cls;
    logic signed [W-1:0] sx_r, sx_i, sy_r, sy_i;
    logic [IW-1:0]       wr_data;
    logic [IW-1:0]       rd_data;
    logic                empty;
    logic                full;

    // b/a and |b| swap operands so the back end only sees x op y
    always_comb
    begin
        cls  = CLS_BAD;
        sx_r = a_real;
        sx_i = a_imag;
        sy_r = b_real;
        sy_i = b_imag;
        case (operation)
            OP_ADD:    cls = CLS_ADD;
            OP_SUB_AB: cls = CLS_SUB;
            OP_SUB_BA:
            begin
                cls  = CLS_SUB;
                sx_r = b_real;
                sx_i = b_imag;
                sy_r = a_real;
                sy_i = a_imag;
            end
            OP_MUL:    cls = CLS_MUL;
            OP_DIV_AB: cls = CLS_DIV;
            OP_DIV_BA:
            begin
                cls  = CLS_DIV;
                sx_r = b_real;
                sx_i = b_imag;
                sy_r = a_real;
                sy_i = a_imag;
            end
            OP_MAG_A:
            begin
                cls  = CLS_MAG;
                sy_r = a_real;
                sy_i = a_imag;
            end
            OP_MAG_B:
            begin
                cls  = CLS_MAG;
                sx_r = b_real;
                sx_i = b_imag;
            end
            default:   cls = CLS_BAD;
        endcase
    end

    assign wr_data = {cls, sx_r, sx_i, sy_r, sy_i};

    cau_fifo #(
        .WIDTH (IW),
        .DEPTH (2)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (start),
        .wr_data (wr_data),
        .pop     (!empty),
        .rd_data (rd_data),
        .empty   (empty),
        .full    (full)
    );

    assign busy     = full;
    assign item_vld = !empty;
    assign item_cls = cls_t'(rd_data[IW-1 -: CLS_W]);
    assign x_r      = rd_data[4*W-1 -: W];
    assign x_i      = rd_data[3*W-1 -: W];
    assign y_r      = rd_data[2*W-1 -: W];
    assign y_i      = rd_data[W-1 -: W];

endmodule

`default_nettype wire

// ===== src/cau_back.sv =====
// ============================================================================
// cau_back - arithmetic pipeline
// Products, sums, magnitudes, then a radix-2 divider and square root pipeline.
// ============================================================================
`default_nettype none

module cau_back
    import cau_pkg::*;
#(
    parameter int W = 16,
    parameter int F = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  cls_t                in_cls,
    input  logic signed [W-1:0] x_r,
    input  logic signed [W-1:0] x_i,
    input  logic signed [W-1:0] y_r,
    input  logic signed [W-1:0] y_i,
    output logic                done,
    output logic signed [W-1:0] res_real,
    output logic signed [W-1:0] res_imag,
    output logic [1:0]          status
);

    localparam int PW = 2 * W;           // product
    localparam int SW = 2 * W + 1;       // sum of products
    localparam int MW = 2 * W;           // magnitude of a sum
    localparam int CW = 3 * W + F + 2;   // divider remainder
    localparam int QW = W + 1;           // quotient / clipped magnitude
    localparam int RW = 2 * W + 2;       // square root work width
    localparam int NS = W + 1;           // iteration stages

    // ---- stage 1: products and add/sub ----
    ctl_t                 c1_reg;
    logic signed [PW-1:0] prr_reg, pii_reg, pri_reg, pir_reg, pbr_reg, pbi_reg;
    logic signed [W:0]    ad0_reg, ad1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
        end
        else
        begin
            c1_reg <= '{vld: in_vld, cls: in_cls, neg0: 1'b0, neg1: 1'b0, divz: 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        prr_reg <= PW'(x_r) * PW'(y_r);
        pii_reg <= PW'(x_i) * PW'(y_i);
        pri_reg <= PW'(x_r) * PW'(y_i);
        pir_reg <= PW'(x_i) * PW'(y_r);
        pbr_reg <= PW'(y_r) * PW'(y_r);
        pbi_reg <= PW'(y_i) * PW'(y_i);
        if (in_cls == CLS_ADD)
        begin
            ad0_reg <= (W+1)'(x_r) + (W+1)'(y_r);
            ad1_reg <= (W+1)'(x_i) + (W+1)'(y_i);
        end
        else
        begin
            ad0_reg <= (W+1)'(x_r) - (W+1)'(y_r);
            ad1_reg <= (W+1)'(x_i) - (W+1)'(y_i);
        end
    end

    // ---- stage 2: combine products ----
    ctl_t                 c2_reg;
    logic signed [SW-1:0] s0_reg, s1_reg;
    logic [MW-1:0]        den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c2_reg <= '0;
        end
        else
        begin
            c2_reg <= c1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= MW'($unsigned(pbr_reg)) + MW'($unsigned(pbi_reg));
        case (c1_reg.cls)
            CLS_ADD, CLS_SUB:
            begin
                s0_reg <= SW'(ad0_reg);
                s1_reg <= SW'(ad1_reg);
            end
            CLS_MUL:
            begin
                s0_reg <= SW'(prr_reg) - SW'(pii_reg);
                s1_reg <= SW'(pri_reg) + SW'(pir_reg);
            end
            default:
            begin
                // divide numerator; for magnitude x==y so s0 is |x|^2
                s0_reg <= SW'(prr_reg) + SW'(pii_reg);
                s1_reg <= SW'(pir_reg) - SW'(pri_reg);
            end
        endcase
    end

    // ---- stage 3: sign/magnitude, lane setup ----
    ctl_t          ctl_reg [NS+1];
    logic [CW-1:0] rem0_reg [NS+1];
    logic [CW-1:0] rem1_reg [NS+1];
    logic [CW-1:0] dv_reg   [NS+1];
    logic [QW-1:0] q0_reg   [NS+1];
    logic [QW-1:0] q1_reg   [NS+1];
    logic [RW-1:0] sn_reg   [NS+1];
    logic [RW-1:0] sr_reg   [NS+1];

    logic [SW-1:0] a0, a1;
    logic [MW-1:0] m0, m1;
    logic [CW-1:0] n0, n1, dlim;
    logic          ovf0, ovf1;
    logic [QW-1:0] q0_init, q1_init;
    ctl_t          c3;

    function automatic logic [QW-1:0] clip(input logic [MW-1:0] v);
        logic [MW-1:0] top;
        top  = MW'(1) << W;
        clip = (v > top) ? QW'(top) : v[QW-1:0];
    endfunction

    always_comb
    begin
        a0   = s0_reg[SW-1] ? SW'(-s0_reg) : SW'(s0_reg);
        a1   = s1_reg[SW-1] ? SW'(-s1_reg) : SW'(s1_reg);
        m0   = a0[MW-1:0];
        m1   = a1[MW-1:0];
        n0   = CW'(m0) << F;
        n1   = CW'(m1) << F;
        dlim = CW'(den_reg) << (W + 1);
        ovf0 = (n0 >= dlim);
        ovf1 = (n1 >= dlim);
        c3      = c2_reg;
        c3.neg0 = s0_reg[SW-1];
        c3.neg1 = s1_reg[SW-1];
        c3.divz = (den_reg == '0);
        case (c2_reg.cls)
            CLS_ADD, CLS_SUB:
            begin
                q0_init = clip(m0);
                q1_init = clip(m1);
            end
            CLS_MUL:
            begin
                q0_init = clip(m0 >> F);
                q1_init = clip(m1 >> F);
            end
            CLS_DIV:
            begin
                // quotient too big: preset all ones, no bits get cleared
                q0_init = ovf0 ? '1 : '0;
                q1_init = ovf1 ? '1 : '0;
            end
            default:
            begin
                q0_init = '0;
                q1_init = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg[0] <= '0;
        end
        else
        begin
            ctl_reg[0] <= c3;
        end
    end

    always_ff @(posedge clk)
    begin
        rem0_reg[0] <= (c2_reg.cls == CLS_DIV && !ovf0) ? n0 : '0;
        rem1_reg[0] <= (c2_reg.cls == CLS_DIV && !ovf1) ? n1 : '0;
        dv_reg[0]   <= CW'(den_reg);
        q0_reg[0]   <= q0_init;
        q1_reg[0]   <= q1_init;
        sn_reg[0]   <= RW'(m0);
        sr_reg[0]   <= '0;
    end

    // ---- iteration stages: one quotient bit and one root bit each ----
    for (genvar k = 0; k < NS; k++)
    begin : g_iter
        localparam int QB = W - k;
        logic [CW-1:0] dsh;
        logic [RW-1:0] rbit;
        logic [RW-1:0] trial;
        logic          div_on;
        logic          t0, t1, ts;

        always_comb
        begin
            dsh    = dv_reg[k] << QB;
            rbit   = RW'(1) << (2 * QB);
            trial  = sr_reg[k] + rbit;
            div_on = (ctl_reg[k].cls == CLS_DIV);
            t0     = div_on && (rem0_reg[k] >= dsh);
            t1     = div_on && (rem1_reg[k] >= dsh);
            ts     = (sn_reg[k] >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k+1] <= '0;
            end
            else
            begin
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_reg[k+1]   <= dv_reg[k];
            rem0_reg[k+1] <= t0 ? rem0_reg[k] - dsh : rem0_reg[k];
            rem1_reg[k+1] <= t1 ? rem1_reg[k] - dsh : rem1_reg[k];
            q0_reg[k+1]   <= q0_reg[k] | (t0 ? QW'(1) << QB : '0);
            q1_reg[k+1]   <= q1_reg[k] | (t1 ? QW'(1) << QB : '0);
            sn_reg[k+1]   <= ts ? sn_reg[k] - trial : sn_reg[k];
            sr_reg[k+1]   <= ts ? (sr_reg[k] >> 1) + rbit : (sr_reg[k] >> 1);
        end
    end

    // ---- output stage: select, saturate, status ----
    ctl_t          cf;
    logic          fneg0, fneg1, sat0, sat1;
    logic [QW-1:0] fm0, fm1, lim0, lim1, cm0, cm1;
    logic [W-1:0]  o0, o1;
    status_t       st;

    logic          done_reg;
    logic [W-1:0]  res_real_reg, res_imag_reg;
    status_t       status_reg;

    always_comb
    begin
        cf    = ctl_reg[NS];
        fneg0 = cf.neg0;
        fneg1 = cf.neg1;
        fm0   = q0_reg[NS];
        fm1   = q1_reg[NS];
        st    = ST_OK;
        case (cf.cls)
            CLS_MAG:
            begin
                fneg0 = 1'b0;
                fneg1 = 1'b0;
                fm0   = sr_reg[NS][QW-1:0];
                fm1   = '0;
            end
            CLS_DIV:
            begin
                if (cf.divz)
                begin
                    fm0 = '0;
                    fm1 = '0;
                    st  = ST_DIVZ;
                end
            end
            CLS_BAD:
            begin
                fm0 = '0;
                fm1 = '0;
                st  = ST_BAD;
            end
            default:
            begin
                st = ST_OK;
            end
        endcase
        lim0 = fneg0 ? QW'(1) << (W - 1) : (QW'(1) << (W - 1)) - 1'b1;
        lim1 = fneg1 ? QW'(1) << (W - 1) : (QW'(1) << (W - 1)) - 1'b1;
        sat0 = fm0 > lim0;
        sat1 = fm1 > lim1;
        cm0  = sat0 ? lim0 : fm0;
        cm1  = sat1 ? lim1 : fm1;
        o0   = fneg0 ? W'(-cm0[W-1:0]) : cm0[W-1:0];
        o1   = fneg1 ? W'(-cm1[W-1:0]) : cm1[W-1:0];
        if (st == ST_OK && (sat0 || sat1))
        begin
            st = ST_SAT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cf.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        res_real_reg <= o0;
        res_imag_reg <= o1;
        status_reg   <= st;
    end

    assign done     = done_reg;
    assign res_real = res_real_reg;
    assign res_imag = res_imag_reg;
    assign status   = status_reg;

endmodule

`default_nettype wire

// ===== dv/complex_arithmetic_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_tb - self-checking bench for the complex ALU
// Drives requests with random gaps, predicts each result with an exact
// integer model (saturation, truncation, floor square root) and checks every
// done pulse in order against the oldest pending prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    localparam int DW       = 16;
    localparam int FB       = 8;
    localparam int LATENCY  = DW + 6;
    localparam int WDOG_MAX = 2000;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        status_t              st;
    } cplx_res_t;

    // Clip a wide exact value to the output format; flags clipping.
    function automatic logic signed [DW-1:0] clip(input longint v, inout bit sat);
        longint hi;
        longint lo;
        begin
            hi = (longint'(1) <<< (DW - 1)) - 1;
            lo = -(longint'(1) <<< (DW - 1));
            if (v > hi) begin sat = 1; return hi[DW-1:0]; end
            if (v < lo) begin sat = 1; return lo[DW-1:0]; end
            return v[DW-1:0];
        end
    endfunction

    // Floor square root; the root of a 32-bit sum fits in 17 bits.
    function automatic longint floor_sqrt(input longint n);
        longint r;
        begin
            r = 0;
            for (longint bitv = longint'(1) <<< 20; bitv != 0; bitv = bitv >>> 1)
                if ((r + bitv) * (r + bitv) <= n) r = r + bitv;
            return r;
        end
    endfunction

    function automatic cplx_res_t predict_op(input logic [3:0] opc,
                                             input logic signed [DW-1:0] ar0,
                                             input logic signed [DW-1:0] ai0,
                                             input logic signed [DW-1:0] br0,
                                             input logic signed [DW-1:0] bi0);
        cplx_res_t r;
        longint ar, ai, br, bi, t, re, im, den;
        bit sat;
        begin
            ar = ar0; ai = ai0; br = br0; bi = bi0;
            re = 0; im = 0; sat = 0;
            r.st = ST_OK;
            if (opc == OP_DIV_BA) begin
                t = ar; ar = br; br = t; t = ai; ai = bi; bi = t;
            end
            if (opc == OP_MAG_B) begin ar = br; ai = bi; end
            case (opc)
                OP_ADD:    begin re = ar + br; im = ai + bi; end
                OP_SUB_AB: begin re = ar - br; im = ai - bi; end
                OP_SUB_BA: begin re = br - ar; im = bi - ai; end
                OP_MUL:    begin
                    re = (ar * br - ai * bi) / (longint'(1) <<< FB);
                    im = (ar * bi + ai * br) / (longint'(1) <<< FB);
                end
                OP_DIV_AB, OP_DIV_BA: begin
                    den = br * br + bi * bi;
                    if (den == 0) r.st = ST_DIVZ;
                    else begin
                        re = ((ar * br + ai * bi) * (longint'(1) <<< FB)) / den;
                        im = ((ai * br - ar * bi) * (longint'(1) <<< FB)) / den;
                    end
                end
                OP_MAG_A, OP_MAG_B: re = floor_sqrt(ar * ar + ai * ai);
                default: r.st = ST_BAD;
            endcase
            r.re = clip(re, sat);
            r.im = clip(im, sat);
            if (r.st == ST_OK && sat) r.st = ST_SAT;
            return r;
        end
    endfunction

    class cau_scoreboard;
        cplx_res_t pending[$];
        int        n_err;
        int        n_checked;

        function void note_request(input logic [3:0] opc, input logic signed [DW-1:0] ar,
                                   input logic signed [DW-1:0] ai,
                                   input logic signed [DW-1:0] br,
                                   input logic signed [DW-1:0] bi);
            pending.push_back(predict_op(opc, ar, ai, br, bi));
        endfunction

        function void check_result(input logic signed [DW-1:0] re,
                                   input logic signed [DW-1:0] im, input logic [1:0] st);
            cplx_res_t e;
            n_checked++;
            if (pending.size() == 0) begin
                n_err++;
                $display("%0t: unexpected result re=%0d im=%0d st=%0d", $time, re, im, st);
                return;
            end
            e = pending.pop_front();
            if (re !== e.re) begin
                n_err++;
                $display("%0t: res_real expected %0d actual %0d", $time, e.re, re);
            end
            if (im !== e.im) begin
                n_err++;
                $display("%0t: res_imag expected %0d actual %0d", $time, e.im, im);
            end
            if (st !== e.st) begin
                n_err++;
                $display("%0t: status expected %0d actual %0d", $time, e.st, st);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [3:0]           operation;
    logic signed [DW-1:0] a_real, a_imag, b_real, b_imag;
    logic                 done;
    logic signed [DW-1:0] res_real, res_imag;
    logic [1:0]           status;

    cau_scoreboard sb;
    int            idle_pct;
    int            wdog = 0;
    int            n_req = 0;
    int            op_seen[16];

    complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .a_real(a_real), .a_imag(a_imag),
        .b_real(b_real), .b_imag(b_imag), .done(done),
        .res_real(res_real), .res_imag(res_imag), .status(status)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    // Sample everything at the rising edge: accepted requests feed the
    // predictor, done pulses are checked, the watchdog counts quiet cycles.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (start && !busy) begin
                sb.note_request(operation, a_real, a_imag, b_real, b_imag);
                op_seen[operation]++;
                n_req++;
            end
            if (done) sb.check_result(res_real, res_imag, status);
            if ((start && !busy) || done) wdog = 0;
            else wdog++;
            if (wdog >= WDOG_MAX) begin
                $display("watchdog: no progress in %0d cycles", WDOG_MAX);
                $display("complex_arithmetic_unit_tb NOT OK");
                $finish;
            end
        end
    end

    // Present one request at the falling edge; hold until accepted.
    // Random idle cycles go in front according to idle_pct.
    task automatic send_req(input logic [3:0] opc, input logic [DW-1:0] ar,
                            input logic [DW-1:0] ai, input logic [DW-1:0] br,
                            input logic [DW-1:0] bi);
        begin
            while ($urandom_range(99) < idle_pct) begin
                start <= 1'b0;
                @(negedge clk);
            end
            start     <= 1'b1;
            operation <= opc;
            a_real    <= ar;
            a_imag    <= ai;
            b_real    <= br;
            b_imag    <= bi;
            @(posedge clk);
            while (busy) @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic idle_bus();
        begin
            start <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Operand picker: half small magnitudes so products and quotients stay
    // in range, with a share of extremes and fully random words.
    function automatic logic [DW-1:0] pick_part();
        int sel;
        begin
            sel = $urandom_range(9);
            case (sel)
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                3, 4: return DW'($urandom_range(16'hFFFF));
                default: return DW'($signed($urandom_range(2048)) - 1024);
            endcase
        end
    endfunction

    task automatic wait_drained();
        begin
            while (sb.pending.size() != 0) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [3:0] opc;
        sb        = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        operation = '0;
        a_real    = '0;
        a_imag    = '0;
        b_real    = '0;
        b_imag    = '0;
        idle_pct  = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: every opcode, extremes, divide by zero both ways,
        // saturation on add and mul, invalid codes.
        for (int k = 0; k < 8; k++)
            send_req(k[3:0], 16'h0180, 16'hFF00, 16'h0040, 16'h0200);
        send_req(OP_ADD,    16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_req(OP_SUB_AB, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_req(OP_SUB_BA, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_req(OP_MUL,    16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_req(OP_MUL,    16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_req(OP_DIV_AB, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
        send_req(OP_DIV_BA, 16'h0000, 16'h0000, 16'h0100, 16'h0100);
        send_req(OP_DIV_AB, 16'h0000, 16'h0000, 16'h0100, 16'h0000);
        send_req(OP_DIV_AB, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000);
        send_req(OP_DIV_BA, 16'h0000, 16'h0001, 16'h8000, 16'h8000);
        send_req(OP_MAG_A,  16'h8000, 16'h8000, 16'h0000, 16'h0000);
        send_req(OP_MAG_B,  16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
        send_req(4'd8,      16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        send_req(4'd15,     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Hold off until the pipe is empty once.
        idle_bus();
        wait_drained();

        // Random phases: back-to-back, sparse, busy-ish mix, back-to-back.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 66;
                2: idle_pct = 14;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < 308; n++) begin
                // invalid codes occasionally, otherwise the eight operations
                opc = ($urandom_range(15) == 0) ? 4'($urandom_range(15, 8))
                                                : 4'($urandom_range(7));
                send_req(opc, pick_part(), pick_part(), pick_part(), pick_part());
            end
        end
        idle_bus();

        wait_drained();
        repeat (LATENCY + 5) @(negedge clk);

        $display("ran %0d requests over all 16 opcodes (mul %0d, div %0d, mag %0d)",
                 n_req, op_seen[OP_MUL], op_seen[OP_DIV_AB] + op_seen[OP_DIV_BA],
                 op_seen[OP_MAG_A] + op_seen[OP_MAG_B]);
        $display("checked %0d results with sender gaps of 0, 14 and 66 percent",
                 sb.n_checked);
        if (sb.n_err == 0 && sb.pending.size() == 0)
            $display("complex_arithmetic_unit_tb OK");
        else
            $display("complex_arithmetic_unit_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/cau_pkg.sv
src/cau_fifo.sv
src/cau_front.sv
src/cau_back.sv
src/complex_arithmetic_unit.sv
dv/complex_arithmetic_unit_tb.sv
